@@ sv/point_in_polygon_test_assert.svh @@
// Assertion macros for the point-in-polygon block
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define PIP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/pip_pkg.sv @@
// Package for the point-in-polygon block: codes, widths and state type
package pip_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] LOC_INSIDE   = 2'd0;
    localparam logic [1:0] LOC_OUTSIDE  = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;
    localparam logic [1:0] LOC_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDA, S_RDB, S_MUL, S_SUB, S_DIV, S_CMP, S_DONE
    } t_state;
endpackage

@@ sv/point_in_polygon_test.sv @@
// Point-in-polygon classifier: vertex store, edge walker and serial divider
//
// Usage: present command, x and y with i_start while o_busy is low; the
// item transfers at that edge. Add (0) stores a vertex with no result, or
// gives location 3 on the next cycle when the store already holds
// MAX_VERTICES vertices. Clear (2) empties the store with no result.
// Query (1) walks every edge, closing edge included, and gives one result:
// 0 inside, 1 outside, 2 boundary. A result appears on o_location for one
// cycle with o_valid. Add and clear leave o_busy low. A query holds o_busy
// for its whole walk, and an edge whose span can cross the ray also passes
// through the divider. The store reads one vertex per cycle through a single
// port, two registered products form the cross term and numerator, and a
// one bit per cycle restoring divider of 34 steps forms the crossing x. A
// boundary hit ends the walk early. The result appears as o_busy falls,
// when the next item may already transfer.
// Reset (synchronous, active low) empties the store and idles the block.
// The receiver cannot stall; results are never held back.
module point_in_polygon_test
    import pip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_command,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    output logic               o_busy,
    output logic               o_valid,
    output logic [1:0]         o_location
);
    `include "point_in_polygon_test_assert.svh"

    // vertex store: one read port, one write port
    logic [31:0] mem [MAX_VERTICES];
    logic [31:0] r_rd;
    logic        we;
    logic [AW-1:0] waddr, raddr;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= {i_x_coord, i_y_coord};
        r_rd <= mem[raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_k;
    logic signed [15:0] r_px, r_py, r_ax, r_ay, r_bx, r_by;
    logic signed [16:0] dx, dy, qx, qy;
    logic signed [33:0] r_m1, r_m2;
    logic               r_par;
    logic signed [33:0] cross_val;
    logic [33:0] r_rem, r_quo;
    logic [16:0] r_den;
    logic        r_neg;
    logic [5:0]  r_step;
    logic        r_valid;
    logic [1:0]  r_loc;
    logic        last;

    assign dx = 17'(r_bx) - 17'(r_ax);
    assign dy = 17'(r_by) - 17'(r_ay);
    assign qx = 17'(r_px) - 17'(r_ax);
    assign qy = 17'(r_py) - 17'(r_ay);
    assign last = ({1'b0, r_k} == CW'(r_count - 1'b1));
    assign cross_val = r_m1 - r_m2;

    logic signed [15:0] minx, maxx, miny, maxy;
    assign minx = (r_ax < r_bx) ? r_ax : r_bx;
    assign maxx = (r_ax < r_bx) ? r_bx : r_ax;
    assign miny = (r_ay < r_by) ? r_ay : r_by;
    assign maxy = (r_ay < r_by) ? r_by : r_ay;

    logic onbox, cand;
    assign onbox = minx <= r_px && r_px <= maxx && miny <= r_py && r_py <= maxy;
    assign cand  = r_px <= maxx && r_py > miny && r_py <= maxy;

    // divider trial subtraction
    logic [34:0] trial;
    logic [33:0] shrem;
    assign shrem = {r_rem[32:0], r_quo[33]};
    assign trial = {1'b0, shrem} - {18'd0, r_den};

    // crossing x = quotient + ax, compared with px
    logic signed [35:0] xc;
    assign xc = (r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo})) + 36'(r_ax);

    always_comb begin
        n_state = r_state;
        we = 1'b0;
        waddr = r_count[AW-1:0];
        raddr = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_command == CMD_ADD && r_count < CW'(MAX_VERTICES)) we = 1'b1;
                    if (i_command == CMD_QUERY) n_state = (r_count == '0) ? S_DONE : S_RD0;
                end
                raddr = '0;
            end
            S_RD0: n_state = S_RDA;
            S_RDA: begin
                raddr = last ? AW'(0) : AW'(r_k + 1'b1);
                n_state = S_RDB;
            end
            S_RDB: n_state = S_MUL;
            S_MUL: n_state = S_SUB;
            S_SUB: n_state = (cross_val == '0 && onbox) ? S_DONE : (cand ? S_DIV : S_CMP);
            S_DIV: if (r_step == 6'd34) n_state = S_CMP;
            S_CMP: begin
                raddr = AW'(r_k + 1'b1);
                n_state = last ? S_DONE : S_RDA;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // advance the walk and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_px <= i_x_coord;
                    r_py <= i_y_coord;
                    r_k <= '0;
                    r_par <= 1'b0;
                    r_loc <= LOC_OUTSIDE;
                    if (i_command == CMD_CLEAR) r_count <= '0;
                    if (i_command == CMD_ADD) begin
                        if (r_count < CW'(MAX_VERTICES)) r_count <= CW'(r_count + 1'b1);
                        else begin
                            r_valid <= 1'b1;
                            r_loc <= LOC_FULL;
                        end
                    end
                end
                S_RDA: begin
                    r_ax <= r_rd[31:16];
                    r_ay <= r_rd[15:0];
                end
                S_RDB: begin
                    r_bx <= r_rd[31:16];
                    r_by <= r_rd[15:0];
                end
                S_MUL: begin
                    r_m1 <= dx * qy;
                    r_m2 <= qx * dy;
                end
                S_SUB: begin
                    r_neg <= r_m1[33] ^ dy[16];
                    r_quo <= r_m1[33] ? 34'(-r_m1) : 34'(r_m1);
                    r_den <= dy[16] ? 17'(-dy) : 17'(dy);
                    r_rem <= '0;
                    r_step <= '0;
                    if (cross_val == '0 && onbox) r_loc <= LOC_BOUNDARY;
                end
                S_DIV: if (r_step != 6'd34) begin
                    r_step <= r_step + 1'b1;
                    if (!trial[34]) begin
                        r_rem <= trial[33:0];
                        r_quo <= {r_quo[32:0], 1'b1};
                    end else begin
                        r_rem <= shrem;
                        r_quo <= {r_quo[32:0], 1'b0};
                    end
                end
                S_CMP: begin
                    r_k <= AW'(r_k + 1'b1);
                    if (cand && (r_ax == r_bx || 36'(r_px) <= xc)) begin
                        r_par <= ~r_par;
                        if (last) r_loc <= r_par ? LOC_OUTSIDE : LOC_INSIDE;
                    end else if (last) r_loc <= r_par ? LOC_INSIDE : LOC_OUTSIDE;
                end
                S_DONE: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_location = r_loc;

    `PIP_ASSERT_IMP(a_cnt, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_VERTICES),
        "vertex count beyond capacity")
    `PIP_ASSERT_NEXT(a_done, i_clk, i_rst_n, r_state == S_DONE, r_valid && r_state == S_IDLE,
        "query finished without a result")
    `PIP_ASSERT_IMP(a_div, i_clk, i_rst_n, r_state == S_DIV, r_den != '0,
        "divide by zero on a crossing edge")
endmodule
